// ----- design/i2cbm_pkg.sv -----
// Package for the I2C bit-level master core: command and status codes,
// sequencer state and slot result types, timing constants. No dependencies.
`timescale 1ns / 1ps

package i2cbm_pkg;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_WRITE     = 3'd3,
        OP_WAIT      = 3'd4,
        OP_READ_ACK  = 3'd5,
        OP_READ_NACK = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ACK_NONE    = 2'd0,
        ACK_SEEN    = 2'd1,
        ACK_TIMEOUT = 2'd2
    } ack_t;

    localparam logic [7:0] TIMEOUT_RESET = 8'd30;
    localparam int         BITS_PER_BYTE = 8;
    localparam logic [4:0] BIT_SLOTS     = 5'(3 * BITS_PER_BYTE);
    localparam logic [4:0] RD_ACK_LOW    = 5'(3 * BITS_PER_BYTE + 1);
    localparam logic [4:0] RD_ACK_HIGH   = 5'(3 * BITS_PER_BYTE + 2);

    typedef struct packed {
        logic [4:0] phase;
        op_t        cmd;
        logic [3:0] bit_count;
        logic [7:0] shift;
        logic [7:0] wait_count;
        logic       scl;
        logic       sda;
    } seq_state_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_byte;
        logic       sda_in;
    } slot_in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       read_done;
        ack_t       ack_status;
    } slot_out_t;

endpackage

// ----- design/i2cbm_seq.sv -----
// Slot sequencer: combinational next state and result for one timing slot.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_seq (
    input  i2cbm_pkg::seq_state_t state_cur,
    input  i2cbm_pkg::slot_in_t   slot,
    input  logic [7:0]            ack_timeout,
    output i2cbm_pkg::seq_state_t state_next,
    output i2cbm_pkg::slot_out_t  result
);
    import i2cbm_pkg::*;

    function automatic logic [1:0] mod3(input logic [4:0] v);
        logic [4:0] x;
        x = v;
        if (x >= 5'd12) x = x - 5'd12;
        if (x >= 5'd6)  x = x - 5'd6;
        if (x >= 5'd3)  x = x - 5'd3;
        return x[1:0];
    endfunction

    seq_state_t st;
    logic       done;
    logic       rd_done;
    logic [7:0] rd_byte;
    ack_t       status;
    logic [1:0] rem;

    always_comb
    begin
        st      = state_cur;
        done    = 1'b0;
        rd_done = 1'b0;
        rd_byte = 8'd0;
        status  = ACK_NONE;
        rem     = 2'd0;

        if (st.cmd == OP_NONE && (slot.operation inside {[OP_START:OP_READ_NACK]}))
        begin
            st.cmd        = op_t'(slot.operation);
            st.phase      = 5'd0;
            st.bit_count  = 4'd0;
            st.wait_count = 8'd0;
            st.shift      = (op_t'(slot.operation) == OP_WRITE) ? slot.write_byte : 8'd0;
        end

        case (st.cmd)
            OP_START:
            begin
                if (st.phase == 5'd0)
                begin
                    st.scl = 1'b1;
                    st.sda = 1'b1;
                end
                else if (st.phase == 5'd1)
                    st.sda = 1'b0;
                else
                begin
                    st.scl = 1'b0;
                    done   = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (st.phase == 5'd0)
                begin
                    st.scl = 1'b0;
                    st.sda = 1'b0;
                end
                else if (st.phase == 5'd1)
                    st.scl = 1'b1;
                else
                begin
                    st.sda = 1'b1;
                    done   = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (st.phase < BIT_SLOTS)
                begin
                    rem = mod3(st.phase);
                    if (rem == 2'd0)
                    begin
                        st.scl = 1'b0;
                        st.sda = st.shift[7];
                    end
                    else if (rem == 2'd1)
                        st.scl = 1'b1;
                    else
                    begin
                        st.scl       = 1'b0;
                        st.shift     = {st.shift[6:0], 1'b0};
                        st.bit_count = st.bit_count + 4'd1;
                    end
                end
                else
                begin
                    st.sda = 1'b1;
                    st.scl = 1'b1;
                    done   = 1'b1;
                end
            end
            OP_WAIT:
            begin
                st.sda = 1'b1;
                if (!slot.sda_in)
                begin
                    st.scl = 1'b0;
                    status = ACK_SEEN;
                    done   = 1'b1;
                end
                else if (st.wait_count >= ack_timeout)
                begin
                    st.scl = 1'b0;
                    status = ACK_TIMEOUT;
                    done   = 1'b1;
                end
                else
                begin
                    st.wait_count = st.wait_count + 8'd1;
                    st.scl        = 1'b1;
                end
            end
            OP_READ_ACK, OP_READ_NACK:
            begin
                if (st.phase == 5'd0)
                begin
                    st.sda = 1'b1;
                    st.scl = 1'b0;
                end
                else if (st.phase <= BIT_SLOTS)
                begin
                    rem = mod3(st.phase - 5'd1);
                    if (rem == 2'd0)
                        st.scl = 1'b1;
                    else if (rem == 2'd1)
                    begin
                        st.shift     = {st.shift[6:0], slot.sda_in};
                        st.bit_count = st.bit_count + 4'd1;
                    end
                    else
                        st.scl = 1'b0;
                end
                else if (st.phase == RD_ACK_LOW)
                begin
                    st.scl = 1'b0;
                    st.sda = (st.cmd == OP_READ_ACK) ? 1'b0 : 1'b1;
                end
                else if (st.phase == RD_ACK_HIGH)
                    st.scl = 1'b1;
                else
                begin
                    st.scl  = 1'b0;
                    rd_done = 1'b1;
                    rd_byte = st.shift;
                    done    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (st.cmd != OP_NONE)
        begin
            if (done)
            begin
                st.cmd   = OP_NONE;
                st.phase = 5'd0;
            end
            else
                st.phase = st.phase + 5'd1;
        end

        state_next        = st;
        result.scl_level  = st.scl;
        result.sda_drive  = st.sda;
        result.busy_res   = (st.cmd != OP_NONE);
        result.read_byte  = rd_byte;
        result.read_done  = rd_done;
        result.ack_status = status;
    end

endmodule

// ----- design/i2cbm_out_stage.sv -----
// Result register with valid/ready handshake toward the master-side stream.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  i2cbm_pkg::slot_out_t load_data,
    output logic                 can_load,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output i2cbm_pkg::slot_out_t m_data
);
    import i2cbm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    slot_out_t data_reg;

    assign can_load   = !valid_reg || m_axis_tready;
    assign valid_next = load || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_data        = data_reg;

endmodule

// ----- design/i2c_bit_level_master_core.sv -----
// I2C bit-level master core, top level: state and timeout registers, slot
// sequencer, result register. Depends on i2cbm_pkg, i2cbm_seq, i2cbm_out_stage.
`timescale 1ns / 1ps

// Each accepted transaction is one bus timing slot and yields exactly one
// result transaction from the result register. One slot is taken every clock
// cycle while s_axis_tready is high; the slot sequencer settles the whole slot
// between the state registers and the result register. s_axis_tready drops
// only while a result waits in the result register and m_axis_tready is low.
// Commands offered while a sequence is busy are ignored. cfg_we loads
// ack_timeout; write it only while no slot is in flight.
module i2c_bit_level_master_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [10:3] write_byte, [11] sda_in, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_drive, [2] busy_res, [10:3] read_byte,
    // [11] read_done, [13:12] ack_status, [15:14] zero
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import i2cbm_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    logic [7:0] timeout_reg;
    slot_in_t   slot;
    slot_out_t  result;
    slot_out_t  m_data;
    logic       accept;
    logic       can_load;

    assign slot.operation  = s_axis_tdata[2:0];
    assign slot.write_byte = s_axis_tdata[10:3];
    assign slot.sda_in     = s_axis_tdata[11];

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    i2cbm_seq u_seq (
        .state_cur  (state_reg),
        .slot       (slot),
        .ack_timeout(timeout_reg),
        .state_next (state_next),
        .result     (result)
    );

    i2cbm_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .load_data    (result),
        .can_load     (can_load),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_data       (m_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= 5'd0;
            state_reg.cmd        <= OP_NONE;
            state_reg.bit_count  <= 4'd0;
            state_reg.shift      <= 8'd0;
            state_reg.wait_count <= 8'd0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
        end
        else if (accept)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_we)
            timeout_reg <= cfg_wdata;
    end

    assign m_axis_tdata = {2'b00, m_data.ack_status, m_data.read_done, m_data.read_byte,
                           m_data.busy_res, m_data.sda_drive, m_data.scl_level};

`ifndef SYNTHESIS
    a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cmd == OP_NONE |-> state_reg.phase == 5'd0)
        else $error("idle sequencer with nonzero phase");

    a_ack_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_data.ack_status != ACK_NONE |-> !m_data.busy_res && !m_data.scl_level)
        else $error("ack status reported while still busy or SCL high");

    a_read_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_data.read_done |-> !m_data.busy_res && !m_data.scl_level)
        else $error("read completion reported while still busy or SCL high");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg))
        else $error("sequencer state moved without an accepted slot");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid && m_data.busy_res == (state_reg.cmd != OP_NONE))
        else $error("result busy flag disagrees with sequencer state");
`endif

endmodule
